/* design/ljpfa_pkg.sv */
// Shared types, constants and saturating helpers for the pair force accumulator.
package ljpfa_pkg;

   typedef logic signed [47:0] acc_type;
   typedef logic [31:0]        pos_type;
   typedef logic [9:0]         index_type;

   localparam acc_type ACC_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam acc_type ACC_MIN = 48'sh8000_0000_0000;
   localparam logic [50:0] NEAR_LIMIT = 51'h400_0000;
   localparam logic [31:0] BOX_RESET = 32'h1000_0000;

   function automatic acc_type sat_sum(input acc_type a, input acc_type b);
      logic signed [48:0] s;
      s = 49'(a) + 49'(b);
      if (s > 49'(ACC_MAX)) begin
         return ACC_MAX;
      end else if (s < 49'(ACC_MIN)) begin
         return ACC_MIN;
      end
      return s[47:0];
   endfunction

   function automatic acc_type sat_diff(input acc_type a, input acc_type b);
      logic signed [48:0] s;
      s = 49'(a) - 49'(b);
      if (s > 49'(ACC_MAX)) begin
         return ACC_MAX;
      end else if (s < 49'(ACC_MIN)) begin
         return ACC_MIN;
      end
      return s[47:0];
   endfunction

endpackage

/* design/ljpfa_ram.sv */
// Generic single write port, single read port RAM with registered read.
module ljpfa_ram #(
   parameter int WIDTH = 144,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* design/ljpfa_mul.sv */
// 64x64 unsigned multiplier built from one 32x32 multiplier over four partial products.
module ljpfa_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic         done,
   output logic [127:0] product
);
   logic [63:0]  a_ff, b_ff;
   logic [2:0]   cnt_ff;
   logic         run_ff, pv_ff, done_ff;
   logic [1:0]   psel_ff;
   logic [63:0]  part_ff;
   logic [127:0] acc_ff;
   logic [31:0]  a_chunk, b_chunk;
   logic [127:0] part_shifted;

   assign a_chunk = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign b_chunk = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];

   always_comb begin
      case (psel_ff)
         2'd0:    part_shifted = {64'd0, part_ff};
         2'd3:    part_shifted = {part_ff, 64'd0};
         default: part_shifted = {32'd0, part_ff, 32'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         pv_ff   <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            a_ff   <= a;
            b_ff   <= b;
            cnt_ff <= 3'd0;
            run_ff <= 1'b1;
            pv_ff  <= 1'b0;
            acc_ff <= 128'd0;
         end else if (run_ff) begin
            if (cnt_ff < 3'd4) begin
               part_ff <= 64'(a_chunk) * 64'(b_chunk);
               psel_ff <= cnt_ff[1:0];
               pv_ff   <= 1'b1;
            end
            if (pv_ff) begin
               acc_ff <= acc_ff + part_shifted;
            end
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               run_ff  <= 1'b0;
               pv_ff   <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

/* design/lj_pair_force_accumulator_top.sv */
// Lennard-Jones pair acceleration accumulator with minimum image wrap, top level.
//
//   channel   ports                       handshake
//   ------    -----                       ---------
//   input     start, busy, req_*          taken when start && !busy
//   result    rsp_valid, rsp_*            one-cycle strobe, no back pressure
//   config    csr_we, csr_wdata           written when csr_we
//
// Work per item, from acceptance until busy falls and the next item can be taken:
// a clear item zeroes one atom; a pair item squares the three components, does a range
// check, then reads both atoms and writes them back unless the distance is zero. When
// the force is computed, a restoring divider and ten more passes of the shared 32x32
// multiplier, one 64x64 product each, come between the range check and the reads.
// Synchronous active-high reset; accumulator memory content is undefined until cleared.
// The result strobe is high in the first cycle with busy low; the receiver cannot stall.
module lj_pair_force_accumulator_top #(
   parameter int ATOM_COUNT = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_kind,
   input  ljpfa_pkg::index_type req_first_index,
   input  ljpfa_pkg::index_type req_second_index,
   input  ljpfa_pkg::pos_type  req_first_pos_x,
   input  ljpfa_pkg::pos_type  req_first_pos_y,
   input  ljpfa_pkg::pos_type  req_first_pos_z,
   input  ljpfa_pkg::pos_type  req_second_pos_x,
   input  ljpfa_pkg::pos_type  req_second_pos_y,
   input  ljpfa_pkg::pos_type  req_second_pos_z,
   output logic                rsp_valid,
   output ljpfa_pkg::acc_type  rsp_first_acc_x,
   output ljpfa_pkg::acc_type  rsp_first_acc_y,
   output ljpfa_pkg::acc_type  rsp_first_acc_z,
   output ljpfa_pkg::acc_type  rsp_second_acc_x,
   output ljpfa_pkg::acc_type  rsp_second_acc_y,
   output ljpfa_pkg::acc_type  rsp_second_acc_z,
   output logic                rsp_degenerate_pair,
   input  logic                csr_we,
   input  ljpfa_pkg::pos_type  csr_wdata
);
   import ljpfa_pkg::*;

   localparam int AW = $clog2(ATOM_COUNT);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_CLR  = 4'd1;
   localparam logic [3:0] ST_MUL  = 4'd2;
   localparam logic [3:0] ST_CHK  = 4'd3;
   localparam logic [3:0] ST_DIV  = 4'd4;
   localparam logic [3:0] ST_RDI  = 4'd5;
   localparam logic [3:0] ST_WRI  = 4'd6;
   localparam logic [3:0] ST_RDJ  = 4'd7;
   localparam logic [3:0] ST_WRJ  = 4'd8;

   localparam logic [3:0] STEP_LAST_SQ = 4'd2;
   localparam logic [3:0] STEP_SS      = 4'd3;
   localparam logic [3:0] STEP_S2S     = 4'd4;
   localparam logic [3:0] STEP_S2S2    = 4'd5;
   localparam logic [3:0] STEP_FORCE   = 4'd6;
   localparam logic [3:0] STEP_LAST    = 4'd12;

   logic [3:0]    state_ff;
   logic [3:0]    step_ff;
   logic          go_ff;
   logic [31:0]   box_ff;
   logic [AW-1:0] idx_i_ff, idx_j_ff, idx_i_in, idx_j_in;
   logic [32:0]   dm_ff [3];
   logic          dneg_ff [3];
   logic [32:0]   dm_in [3];
   logic          dneg_in [3];
   logic [66:0]   r2_ff;
   logic [50:0]   rr_ff;
   logic [50:0]   rem_ff;
   logic [63:0]   quo_ff;
   logic [6:0]    dcnt_ff;
   logic [63:0]   s2_ff, s3_ff, s4_ff;
   logic [79:0]   f_ff;
   logic [127:0]  pa_ff;
   acc_type       acc_ff [3];
   logic          deg_ff;
   acc_type       first_ff [3];
   logic          rsp_valid_ff, rsp_deg_ff;
   acc_type       rsp_first_ff [3];
   acc_type       rsp_second_ff [3];

   logic [63:0]   mul_a, mul_b;
   logic          mul_done;
   logic [127:0]  mul_p;
   logic [1:0]    comp_k;
   logic [65:0]   two_s3;
   logic          tneg;
   logic [63:0]   tm;
   logic [51:0]   trial;
   logic          trial_ge;
   logic [100:0]  f_wide;
   logic [129:0]  p_total;
   logic [97:0]   p_shift;
   logic [46:0]   m_sat;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [143:0]  ram_wdata, ram_rdata;
   acc_type       rd [3];
   acc_type       new_i [3];
   acc_type       new_j [3];

   pos_type       pos_a [3];
   pos_type       pos_b [3];

   assign pos_a[0] = req_first_pos_x;
   assign pos_a[1] = req_first_pos_y;
   assign pos_a[2] = req_first_pos_z;
   assign pos_b[0] = req_second_pos_x;
   assign pos_b[1] = req_second_pos_y;
   assign pos_b[2] = req_second_pos_z;

   // index reduction modulo the atom count by shifted subtraction
   always_comb begin
      logic [26:0] mi, mj, lim;
      mi = 27'(req_first_index);
      mj = 27'(req_second_index);
      for (int sh = 9; sh >= 0; sh--) begin
         lim = 27'(ATOM_COUNT) << sh;
         if (mi >= lim) begin
            mi = mi - lim;
         end
         if (mj >= lim) begin
            mj = mj - lim;
         end
      end
      idx_i_in = mi[AW-1:0];
      idx_j_in = mj[AW-1:0];
   end

   // minimum image displacement per component
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [34:0] d, len;
         d   = 35'(signed'({1'b0, pos_a[k]})) - 35'(signed'({1'b0, pos_b[k]}));
         len = 35'(signed'({1'b0, box_ff}));
         if ((d <<< 1) > len) begin
            d = d - len;
         end else if ((d <<< 1) < -len) begin
            d = d + len;
         end
         dneg_in[k] = d[34];
         dm_in[k]   = d[34] ? 33'(-d) : d[32:0];
      end
   end

   assign two_s3 = {1'b0, s3_ff, 1'b0};
   assign tneg   = two_s3 < 66'h1_0000_0000;
   assign tm     = tneg ? 64'(66'h1_0000_0000 - two_s3) : 64'(two_s3 - 66'h1_0000_0000);

   assign comp_k = 2'((step_ff - 4'd7) >> 1);

   always_comb begin
      case (step_ff)
         4'd0, 4'd1, 4'd2: begin
            mul_a = 64'(dm_ff[step_ff[1:0]]);
            mul_b = 64'(dm_ff[step_ff[1:0]]);
         end
         STEP_SS: begin
            mul_a = quo_ff;
            mul_b = quo_ff;
         end
         STEP_S2S: begin
            mul_a = s2_ff;
            mul_b = quo_ff;
         end
         STEP_S2S2: begin
            mul_a = s2_ff;
            mul_b = s2_ff;
         end
         STEP_FORCE: begin
            mul_a = s4_ff;
            mul_b = tm;
         end
         4'd7, 4'd9, 4'd11: begin
            mul_a = f_ff[63:0];
            mul_b = 64'(dm_ff[comp_k]);
         end
         default: begin
            mul_a = 64'(f_ff[79:64]);
            mul_b = 64'(dm_ff[comp_k]);
         end
      endcase
   end

   ljpfa_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .go      (go_ff),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   assign trial    = {rem_ff, dcnt_ff == 7'd0};
   assign trial_ge = trial >= {1'b0, rr_ff};

   assign f_wide  = (101'(mul_p[127:32]) << 4) + (101'(mul_p[127:32]) << 3);
   assign p_total = {2'b00, pa_ff} + {2'b00, mul_p[63:0], 64'd0};
   assign p_shift = p_total[129:32];
   assign m_sat   = (p_shift > 98'(ACC_MAX)) ? ACC_MAX[46:0] : p_shift[46:0];

   assign rd[0] = ram_rdata[47:0];
   assign rd[1] = ram_rdata[95:48];
   assign rd[2] = ram_rdata[143:96];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         new_i[k] = sat_sum(rd[k], acc_ff[k]);
         new_j[k] = sat_diff(rd[k], acc_ff[k]);
      end
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = idx_i_ff;
      ram_wdata = {new_i[2], new_i[1], new_i[0]};
      ram_raddr = (state_ff == ST_RDJ) ? idx_j_ff : idx_i_ff;
      case (state_ff)
         ST_CLR: begin
            ram_we    = 1'b1;
            ram_wdata = 144'd0;
         end
         ST_WRI: begin
            ram_we = !deg_ff;
         end
         ST_WRJ: begin
            ram_we    = !deg_ff;
            ram_waddr = idx_j_ff;
            ram_wdata = {new_j[2], new_j[1], new_j[0]};
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   ljpfa_ram #(
      .WIDTH (144),
      .DEPTH (ATOM_COUNT)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 4'd0;
         go_ff        <= 1'b0;
         box_ff       <= BOX_RESET;
         rsp_valid_ff <= 1'b0;
         dcnt_ff      <= 7'd0;
      end else begin
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            box_ff <= csr_wdata;
         end
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  idx_i_ff <= idx_i_in;
                  idx_j_ff <= idx_j_in;
                  for (int k = 0; k < 3; k++) begin
                     dm_ff[k]   <= dm_in[k];
                     dneg_ff[k] <= dneg_in[k];
                  end
                  deg_ff  <= 1'b0;
                  step_ff <= 4'd0;
                  if (req_kind) begin
                     state_ff <= ST_MUL;
                     go_ff    <= 1'b1;
                  end else begin
                     state_ff <= ST_CLR;
                  end
               end
            end
            ST_CLR: begin
               for (int k = 0; k < 3; k++) begin
                  rsp_first_ff[k]  <= '0;
                  rsp_second_ff[k] <= '0;
               end
               rsp_deg_ff   <= 1'b0;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            ST_MUL: begin
               if (mul_done) begin
                  case (step_ff)
                     4'd0:      r2_ff <= mul_p[66:0];
                     4'd1, 4'd2: r2_ff <= r2_ff + mul_p[66:0];
                     STEP_SS:   s2_ff <= mul_p[95:32];
                     STEP_S2S:  s3_ff <= mul_p[95:32];
                     STEP_S2S2: s4_ff <= mul_p[95:32];
                     STEP_FORCE: f_ff <= f_wide[79:0];
                     4'd7, 4'd9, 4'd11: pa_ff <= mul_p;
                     default: begin
                        if (tneg != dneg_ff[comp_k]) begin
                           acc_ff[comp_k] <= -acc_type'({1'b0, m_sat});
                        end else begin
                           acc_ff[comp_k] <= acc_type'({1'b0, m_sat});
                        end
                     end
                  endcase
                  if (step_ff == STEP_LAST_SQ) begin
                     state_ff <= ST_CHK;
                  end else if (step_ff == STEP_LAST) begin
                     state_ff <= ST_RDI;
                  end else begin
                     step_ff <= step_ff + 4'd1;
                     go_ff   <= 1'b1;
                  end
               end
            end
            ST_CHK: begin
               rr_ff <= r2_ff[66:16];
               if (r2_ff == 67'd0) begin
                  deg_ff   <= 1'b1;
                  state_ff <= ST_RDI;
               end else if (r2_ff[66:16] <= NEAR_LIMIT) begin
                  for (int k = 0; k < 3; k++) begin
                     if (dneg_ff[k]) begin
                        acc_ff[k] <= -ACC_MAX;
                     end else if (dm_ff[k] != 33'd0) begin
                        acc_ff[k] <= ACC_MAX;
                     end else begin
                        acc_ff[k] <= '0;
                     end
                  end
                  state_ff <= ST_RDI;
               end else begin
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  dcnt_ff  <= 7'd0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff  <= trial_ge ? 51'(trial - {1'b0, rr_ff}) : trial[50:0];
               quo_ff  <= {quo_ff[62:0], trial_ge};
               dcnt_ff <= dcnt_ff + 7'd1;
               if (dcnt_ff == 7'd64) begin
                  step_ff  <= STEP_SS;
                  go_ff    <= 1'b1;
                  state_ff <= ST_MUL;
               end
            end
            ST_RDI: begin
               state_ff <= ST_WRI;
            end
            ST_WRI: begin
               for (int k = 0; k < 3; k++) begin
                  first_ff[k] <= deg_ff ? rd[k] : new_i[k];
               end
               state_ff <= ST_RDJ;
            end
            ST_RDJ: begin
               state_ff <= ST_WRJ;
            end
            ST_WRJ: begin
               for (int k = 0; k < 3; k++) begin
                  rsp_first_ff[k]  <= (!deg_ff && idx_i_ff == idx_j_ff) ? new_j[k]
                                                                        : first_ff[k];
                  rsp_second_ff[k] <= deg_ff ? rd[k] : new_j[k];
               end
               rsp_deg_ff   <= deg_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy                = state_ff != ST_IDLE;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_first_acc_x     = rsp_first_ff[0];
   assign rsp_first_acc_y     = rsp_first_ff[1];
   assign rsp_first_acc_z     = rsp_first_ff[2];
   assign rsp_second_acc_x    = rsp_second_ff[0];
   assign rsp_second_acc_y    = rsp_second_ff[1];
   assign rsp_second_acc_z    = rsp_second_ff[2];
   assign rsp_degenerate_pair = rsp_deg_ff;
endmodule

/* design/ljpfa_checker.sv */
// Port-level checks for the pair force accumulator, bound to the top level.
module ljpfa_port_checks (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("activity right after reset");
endmodule

bind lj_pair_force_accumulator_top ljpfa_port_checks u_chk (.*);

/* test/ljpfa_tb_pkg.sv */
// Item kind codes shared by the pair force accumulator testbench files.
`timescale 1ns / 100ps
package ljpfa_tb_pkg;

   typedef enum logic {
      KIND_CLEAR = 1'b0,
      KIND_PAIR  = 1'b1
   } item_kind_type;

endpackage

/* test/ljpfa_checker.sv */
// Predicts the accumulator sums for each accepted item and compares every result.
`timescale 1ns / 100ps
module ljpfa_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic                 req_kind,
   input  ljpfa_pkg::index_type req_first_index,
   input  ljpfa_pkg::index_type req_second_index,
   input  ljpfa_pkg::pos_type   req_first_pos_x,
   input  ljpfa_pkg::pos_type   req_first_pos_y,
   input  ljpfa_pkg::pos_type   req_first_pos_z,
   input  ljpfa_pkg::pos_type   req_second_pos_x,
   input  ljpfa_pkg::pos_type   req_second_pos_y,
   input  ljpfa_pkg::pos_type   req_second_pos_z,
   input  logic                 rsp_valid,
   input  ljpfa_pkg::acc_type   rsp_first_acc_x,
   input  ljpfa_pkg::acc_type   rsp_first_acc_y,
   input  ljpfa_pkg::acc_type   rsp_first_acc_z,
   input  ljpfa_pkg::acc_type   rsp_second_acc_x,
   input  ljpfa_pkg::acc_type   rsp_second_acc_y,
   input  ljpfa_pkg::acc_type   rsp_second_acc_z,
   input  logic                 rsp_degenerate_pair,
   input  logic                 csr_we,
   input  ljpfa_pkg::pos_type   csr_wdata,
   output int                   fail_count,
   output int                   sums_pending
);
   import ljpfa_pkg::*;
   import ljpfa_tb_pkg::*;

   typedef struct packed {
      acc_type first_x, first_y, first_z;
      acc_type second_x, second_y, second_z;
      logic    degenerate;
   } sums_type;

   localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF;
   localparam longint SUM_MIN = -64'sh8000_0000_0000;

   longint   sum_x[1024], sum_y[1024], sum_z[1024];
   pos_type  box;
   sums_type expected_sums[$];

   function automatic longint clamp48(input longint v);
      if (v > SUM_MAX) return SUM_MAX;
      if (v < SUM_MIN) return SUM_MIN;
      return v;
   endfunction

   function automatic longint min_image(input pos_type a, input pos_type b);
      longint d, len;
      d = longint'({32'b0, a}) - longint'({32'b0, b});
      len = longint'({32'b0, box});
      if (2 * d > len) d = d - len;
      else if (2 * d < -len) d = d + len;
      return d;
   endfunction

   function automatic sums_type predict_sums(input logic kind, input index_type fi,
                                             input index_type si, input pos_type ax,
                                             input pos_type ay, input pos_type az,
                                             input pos_type bx, input pos_type by,
                                             input pos_type bz);
      sums_type    res;
      longint      d[3], acc[3];
      logic [63:0] dm[3], r, s2, s3, s4, tm;
      logic [127:0] r2, rq, s, f, p, m;
      longint      t;
      res = '0;
      if (kind == KIND_CLEAR) begin
         sum_x[fi] = 0;
         sum_y[fi] = 0;
         sum_z[fi] = 0;
         return res;
      end
      d[0] = min_image(ax, bx);
      d[1] = min_image(ay, by);
      d[2] = min_image(az, bz);
      r2 = '0;
      for (int k = 0; k < 3; k++) begin
         dm[k] = d[k] < 0 ? 64'(-d[k]) : 64'(d[k]);
         r2 = r2 + {64'b0, dm[k]} * {64'b0, dm[k]};
      end
      if (r2 == 0) begin
         res.degenerate = 1'b1;
      end else begin
         rq = r2 >> 16;
         r = rq[127:64] != 0 ? 64'hFFFF_FFFF_FFFF_FFFF : rq[63:0];
         if (r <= 64'h400_0000) begin
            for (int k = 0; k < 3; k++)
               acc[k] = d[k] > 0 ? SUM_MAX : (d[k] < 0 ? -SUM_MAX : 0);
         end else begin
            s = (128'd1 << 64) / {64'b0, r};
            rq = (s * s) >> 32;
            s2 = rq[63:0];
            rq = ({64'b0, s2} * s) >> 32;
            s3 = rq[63:0];
            rq = ({64'b0, s2} * {64'b0, s2}) >> 32;
            s4 = rq[63:0];
            t = longint'(2 * s3) - 64'sh1_0000_0000;
            tm = t < 0 ? 64'(-t) : 64'(t);
            f = (({64'b0, s4} * {64'b0, tm}) >> 32) * 128'd24;
            for (int k = 0; k < 3; k++) begin
               p = (f * {64'b0, dm[k]}) >> 32;
               m = p > 128'(SUM_MAX) ? 128'(SUM_MAX) : p;
               acc[k] = ((t < 0) != (d[k] < 0)) ? -longint'(m[63:0]) : longint'(m[63:0]);
            end
         end
         sum_x[fi] = clamp48(sum_x[fi] + acc[0]);
         sum_y[fi] = clamp48(sum_y[fi] + acc[1]);
         sum_z[fi] = clamp48(sum_z[fi] + acc[2]);
         sum_x[si] = clamp48(sum_x[si] - acc[0]);
         sum_y[si] = clamp48(sum_y[si] - acc[1]);
         sum_z[si] = clamp48(sum_z[si] - acc[2]);
      end
      res.first_x = sum_x[fi][47:0];
      res.first_y = sum_y[fi][47:0];
      res.first_z = sum_z[fi][47:0];
      res.second_x = sum_x[si][47:0];
      res.second_y = sum_y[si][47:0];
      res.second_z = sum_z[si][47:0];
      return res;
   endfunction

   initial begin
      fail_count = 0;
      box = BOX_RESET;
      for (int n = 0; n < 1024; n++) begin
         sum_x[n] = 0;
         sum_y[n] = 0;
         sum_z[n] = 0;
      end
   end

   assign sums_pending = expected_sums.size();

   always @(posedge clock) begin
      sums_type want, got;
      if (reset) begin
         box <= BOX_RESET;
      end else begin
         if (csr_we) box <= csr_wdata;
         if (rsp_valid) begin
            got = {rsp_first_acc_x, rsp_first_acc_y, rsp_first_acc_z, rsp_second_acc_x,
                   rsp_second_acc_y, rsp_second_acc_z, rsp_degenerate_pair};
            if (expected_sums.size() == 0) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10) $display("unexpected result %h", got);
            end else begin
               want = expected_sums.pop_front();
               if (got !== want) begin
                  fail_count = fail_count + 1;
                  if (fail_count <= 10)
                     $display("mismatch at %0t\n  exp %h %h %h / %h %h %h deg %b\n  got %h %h %h / %h %h %h deg %b",
                              $realtime, want.first_x, want.first_y, want.first_z,
                              want.second_x, want.second_y, want.second_z, want.degenerate,
                              got.first_x, got.first_y, got.first_z, got.second_x,
                              got.second_y, got.second_z, got.degenerate);
               end
            end
         end
         if (start && !busy)
            expected_sums.push_back(predict_sums(req_kind, req_first_index, req_second_index,
                                                 req_first_pos_x, req_first_pos_y,
                                                 req_first_pos_z, req_second_pos_x,
                                                 req_second_pos_y, req_second_pos_z));
      end
   end

endmodule

/* test/testbench.sv */
// Stimulus, reset, clock and verdict for the pair force accumulator testbench.
`timescale 1ns / 100ps
module testbench;
   import ljpfa_pkg::*;
   import ljpfa_tb_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   logic      req_kind = 1'b0;
   index_type req_first_index = '0, req_second_index = '0;
   pos_type   req_first_pos_x = '0, req_first_pos_y = '0, req_first_pos_z = '0;
   pos_type   req_second_pos_x = '0, req_second_pos_y = '0, req_second_pos_z = '0;
   logic      rsp_valid, rsp_degenerate_pair;
   acc_type   rsp_first_acc_x, rsp_first_acc_y, rsp_first_acc_z;
   acc_type   rsp_second_acc_x, rsp_second_acc_y, rsp_second_acc_z;
   logic      csr_we = 1'b0;
   pos_type   csr_wdata = '0;
   int        fail_count, sums_pending;
   int        quiet_cycles = 0;
   int        item_count = 0;
   int        sender_idle_pct = 24;
   int        cleared[$];

   always #10 clock = ~clock;

   lj_pair_force_accumulator_top i_dut (.*);

   ljpfa_checker i_checker (.*);

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_item(input item_kind_type kind, input int fi, input int si,
                            input pos_type ax, input pos_type ay, input pos_type az,
                            input pos_type bx, input pos_type by, input pos_type bz);
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_first_index <= index_type'(fi);
      req_second_index <= index_type'(si);
      req_first_pos_x <= ax;
      req_first_pos_y <= ay;
      req_first_pos_z <= az;
      req_second_pos_x <= bx;
      req_second_pos_y <= by;
      req_second_pos_z <= bz;
      do @(negedge clock); while (busy);
      @(posedge clock);
      item_count++;
      if (kind == KIND_CLEAR) cleared.push_back(fi);
   endtask

   task automatic clear_atom(input int idx);
      send_item(KIND_CLEAR, idx, $urandom_range(1023), $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (sums_pending != 0);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_box(input pos_type value);
      drain_results();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic pos_type nudge(input pos_type p);
      int sh;
      sh = $urandom_range(18, 28);
      return p + pos_type'($urandom_range((1 << sh) - 1)) - pos_type'(1 << (sh - 1));
   endfunction

   task automatic random_item();
      pos_type ax, ay, az, bx, by, bz;
      int      fi, si, mode;
      if ($urandom_range(99) < 12) begin
         clear_atom($urandom_range(1023));
         return;
      end
      fi = cleared[$urandom_range(cleared.size() - 1)];
      si = $urandom_range(19) == 0 ? fi : cleared[$urandom_range(cleared.size() - 1)];
      ax = $urandom;
      ay = $urandom;
      az = $urandom;
      mode = $urandom_range(9);
      if (mode < 6) begin
         bx = nudge(ax);
         by = nudge(ay);
         bz = nudge(az);
      end else if (mode == 6) begin
         bx = ax;
         by = ay;
         bz = az;
      end else if (mode == 7) begin
         bx = ax + pos_type'($urandom_range(3)) - 2;
         by = ay;
         bz = az + pos_type'($urandom_range(3));
      end else begin
         bx = $urandom;
         by = $urandom;
         bz = $urandom;
      end
      send_item(KIND_PAIR, fi, si, ax, ay, az, bx, by, bz);
   endtask

   initial begin
      pos_type boxes[5];
      boxes = '{32'h0600_0000, 32'hFFFF_FFFF, 32'd1, 32'h0000_0000, BOX_RESET};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items
      clear_atom(0);
      clear_atom(1023);
      clear_atom(1);
      clear_atom(512);
      send_item(KIND_PAIR, 0, 1023, 32'h0100_0000, 32'h0200_0000, 32'h0300_0000,
                32'h0100_0000, 32'h0200_0000, 32'h0300_0000);
      send_item(KIND_PAIR, 0, 1, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000,
                32'h0200_0000, 32'h0100_0000, 32'h0100_0000);
      send_item(KIND_PAIR, 1, 0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                32'h0F80_0000, 32'h0000_0000, 32'h00E0_0000);
      send_item(KIND_PAIR, 512, 512, 32'h0500_0000, 32'h0500_0000, 32'h0500_0000,
                32'h0400_0000, 32'h0500_0000, 32'h0600_0000);
      send_item(KIND_PAIR, 1023, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      repeat (3)
         send_item(KIND_PAIR, 1, 1023, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000,
                   32'h0100_0100, 32'h00FF_FF00, 32'h0100_0000);
      send_item(KIND_PAIR, 0, 512, 32'h0800_0000, 32'h0000_0000, 32'h0000_0000,
                32'h0000_0000, 32'h0800_0000, 32'h0000_0000);
      send_item(KIND_PAIR, 1, 0, 32'h0112_0000, 32'h0100_0000, 32'h0100_0000,
                32'h0000_0000, 32'h0100_0000, 32'h0100_0000);
      clear_atom(1023);
      send_item(KIND_PAIR, 1023, 1, 32'h0300_0000, 32'h0300_0000, 32'h0300_0000,
                32'h0300_0000, 32'h0300_0000, 32'h0300_0000);

      for (int phase = 0; phase < 5; phase++) begin
         if (phase != 3) set_box(boxes[phase]);
         else set_box(pos_type'($urandom_range(32'h0800_0000, 32'h2000_0000)));
         for (int n = 0; n < 150; n++) begin
            if (item_count > 500) sender_idle_pct = 0;
            else if (item_count > 260) sender_idle_pct = 82;
            if (n == 75 && phase == 2) drain_results();
            random_item();
         end
      end

      drain_results();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
design/ljpfa_pkg.sv
design/ljpfa_ram.sv
design/ljpfa_mul.sv
design/lj_pair_force_accumulator_top.sv
design/ljpfa_checker.sv
test/ljpfa_tb_pkg.sv
test/ljpfa_checker.sv
test/testbench.sv
